/* rtl/core/exlx_pkg.sv */
// Shared types, constants and helpers for the expression lexer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package exlx_pkg;

  // width of all position counters and position fields
  localparam int POS_W = 16;

  typedef logic [POS_W-1:0] pos_t;

  // scanner modes of the back end
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT,
    MODE_FRAC,
    MODE_LT,
    MODE_GT,
    MODE_HALT
  } scan_mode_t;

  // token kinds as seen on the result channel
  typedef enum logic [3:0] {
    KIND_IDENT  = 4'd0,
    KIND_NUMBER = 4'd1,
    KIND_LPAREN = 4'd2,
    KIND_RPAREN = 4'd3,
    KIND_PLUS   = 4'd4,
    KIND_MINUS  = 4'd5,
    KIND_STAR   = 4'd6,
    KIND_SLASH  = 4'd7,
    KIND_EQ     = 4'd8,
    KIND_LT     = 4'd9,
    KIND_LE     = 4'd10,
    KIND_GT     = 4'd11,
    KIND_GE     = 4'd12,
    KIND_ERROR  = 4'd13
  } kind_t;

  // character classes produced by the front end
  typedef enum logic [3:0] {
    CLS_LETTER,
    CLS_DIGIT,
    CLS_DOT,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_PLUS,
    CLS_MINUS,
    CLS_STAR,
    CLS_SLASH,
    CLS_EQ,
    CLS_LT,
    CLS_GT,
    CLS_SPACE,
    CLS_NEWLINE,
    CLS_OTHER
  } char_class_t;

  // one classified input word
  typedef struct packed {
    char_class_t cls;
    logic        eot;
  } item_t;

  // head of the front-to-back queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // one token result
  typedef struct packed {
    kind_t kind;
    pos_t  start_offset;
    pos_t  end_offset;
    pos_t  line_number;
    pos_t  column_number;
    logic  last_of_run;
  } token_t;

  // saturating increment of a position
  function automatic pos_t sat_inc(input pos_t v);
    sat_inc = (v == {POS_W{1'b1}}) ? v : v + pos_t'(1);
  endfunction

  function automatic token_t make_tok(input kind_t k, input pos_t s, input pos_t e,
                                      input pos_t l, input pos_t c);
    make_tok = '{kind: k, start_offset: s, end_offset: e, line_number: l,
                 column_number: c, last_of_run: 1'b0};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/exlx_if.sv */
// Channel interfaces of the expression lexer: text bytes in, tokens out.
// Depends on exlx_pkg for the position width.
`default_nettype none

interface exlx_in_if
  import exlx_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
  modport mon    (input valid, input text_byte, input end_of_text, input ready);
endinterface

interface exlx_out_if
  import exlx_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  pos_t       start_offset;
  pos_t       end_offset;
  pos_t       line_number;
  pos_t       column_number;
  logic       last_of_run;

  modport source (output valid, output token_kind, output start_offset,
                  output end_offset, output line_number, output column_number,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input end_offset, input line_number, input column_number,
                  input last_of_run, output ready);
  modport mon    (input valid, input token_kind, input start_offset,
                  input end_offset, input line_number, input column_number,
                  input last_of_run, input ready);
endinterface

`default_nettype wire

/* rtl/core/expression_lexer.sv */
// Top level of the expression lexer: front end, queue and back end.
// Depends on exlx_pkg, exlx_if, exlx_front, exlx_queue and exlx_back.
//
// The lexer takes one text byte per word on text_in and returns tokens on
// token_out with kind, start and end offset, and the line and column where
// each starts. A new byte is taken every cycle while the queue has room; a
// byte can complete zero, one or two tokens, and the single output port
// passes them one at a time, so a run of bytes that each complete two
// tokens holds up the input. A taken byte is registered in a two-word queue
// before it reaches the scanner, and its tokens are registered in the
// output buffer when the scanner takes it. The scanner holds a two-token
// output buffer and takes a byte only when the buffer can absorb both
// tokens it might produce. An unrecognized byte gives an error token and
// the lexer then drops every further byte until reset. A byte with
// end_of_text set flushes any pending token and restarts the counters for
// the next text. No clearing pass is needed after reset.
`default_nettype none

module expression_lexer
  import exlx_pkg::*;
  (
  input  wire        clk,
  input  wire        rst,
  exlx_in_if.sink    text_in,
  exlx_out_if.source token_out
);

  logic    push;
  item_t   push_item;
  logic    q_full;
  logic    pop;
  q_head_t head;

  exlx_front u_front (
    .text_in   (text_in),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  exlx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .head      (head)
  );

  exlx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .token_out (token_out)
  );

endmodule

`default_nettype wire

/* rtl/core/exlx_front.sv */
// Front end: takes text bytes and sorts each into a character class.
// Depends on exlx_pkg and exlx_in_if; feeds exlx_queue.
`default_nettype none

module exlx_front
  import exlx_pkg::*;
  (
  exlx_in_if.sink text_in,
  input  wire     q_full,
  output logic    push,
  output item_t   push_item
);

  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UZ      = 8'h5A;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LZ      = 8'h7A;

  logic [7:0]  b;
  char_class_t cls;

  assign b = text_in.text_byte;

  // classify the byte
  always_comb begin
    priority if (b >= CH_0 && b <= CH_9)                                  cls = CLS_DIGIT;
    else if ((b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ))    cls = CLS_LETTER;
    else if (b == CH_DOT)                                                 cls = CLS_DOT;
    else if (b == CH_LPAREN)                                              cls = CLS_LPAREN;
    else if (b == CH_RPAREN)                                              cls = CLS_RPAREN;
    else if (b == CH_PLUS)                                                cls = CLS_PLUS;
    else if (b == CH_MINUS)                                               cls = CLS_MINUS;
    else if (b == CH_STAR)                                                cls = CLS_STAR;
    else if (b == CH_SLASH)                                               cls = CLS_SLASH;
    else if (b == CH_EQ)                                                  cls = CLS_EQ;
    else if (b == CH_LT)                                                  cls = CLS_LT;
    else if (b == CH_GT)                                                  cls = CLS_GT;
    else if (b == CH_SPACE || b == CH_TAB)                                cls = CLS_SPACE;
    else if (b == CH_NEWLINE)                                             cls = CLS_NEWLINE;
    else                                                                  cls = CLS_OTHER;
  end

  // accept a word whenever the queue has room
  assign text_in.ready = !q_full;
  assign push          = text_in.valid && !q_full;
  assign push_item     = '{cls: cls, eot: text_in.end_of_text};

endmodule

`default_nettype wire

/* rtl/core/exlx_queue.sv */
// Two-entry queue of classified words between front and back end.
// Depends on exlx_pkg.
`default_nettype none

module exlx_queue
  import exlx_pkg::*;
  (
  input  wire        clk,
  input  wire        rst,
  input  wire        push,
  input  wire item_t push_item,
  input  wire        pop,
  output logic       full,
  output q_head_t    head
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

  // store pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/exlx_back.sv */
// Back end: scanner state, position counters, token building and the
// two-token output buffer. Depends on exlx_pkg and exlx_out_if.
`default_nettype none

module exlx_back
  import exlx_pkg::*;
  (
  input  wire          clk,
  input  wire          rst,
  input  wire q_head_t head,
  output logic         pop,
  exlx_out_if.source   token_out
);

  // scanner state
  scan_mode_t mode, mode_proc, mode_next;
  pos_t       off, line, col, ts_off, ts_line, ts_col;
  pos_t       off_next, line_next, col_next, ts_off_next, ts_line_next, ts_col_next;

  // output buffer
  token_t     buf0, buf1;
  logic [1:0] ocnt;

  char_class_t cls;
  logic        eot;
  logic        fresh, mark, live, flush;
  pos_t        off_inc, ts_off_m, ts_line_m, ts_col_m;
  token_t      t1, t2, t3, r0, r1;
  logic        v1, v2, v3;
  logic [1:0]  n;
  logic        out_pop, room;

  assign cls     = head.item.cls;
  assign eot     = head.item.eot;
  assign live    = (mode != MODE_HALT);
  assign off_inc = sat_inc(off);

  // next mode: finish the pending token, then start from the new byte
  always_comb begin
    fresh     = 1'b1;
    mode_proc = mode;
    unique case (mode)
      MODE_IDENT: begin
        if (cls == CLS_LETTER || cls == CLS_DIGIT) fresh = 1'b0;
        else mode_proc = MODE_IDLE;
      end
      MODE_INT: begin
        if (cls == CLS_DIGIT) begin
          fresh = 1'b0;
        end else if (cls == CLS_DOT) begin
          fresh     = 1'b0;
          mode_proc = MODE_FRAC;
        end else begin
          mode_proc = MODE_IDLE;
        end
      end
      MODE_FRAC: begin
        if (cls == CLS_DIGIT) fresh = 1'b0;
        else mode_proc = MODE_IDLE;
      end
      MODE_LT, MODE_GT: begin
        if (cls == CLS_EQ) fresh = 1'b0;
        mode_proc = MODE_IDLE;
      end
      MODE_HALT: begin
        fresh = 1'b0;
      end
      default: begin
        mode_proc = MODE_IDLE;
      end
    endcase
    if (fresh) begin
      unique case (cls)
        CLS_LT:            mode_proc = MODE_LT;
        CLS_GT:            mode_proc = MODE_GT;
        CLS_DIGIT:         mode_proc = MODE_INT;
        CLS_LETTER:        mode_proc = MODE_IDENT;
        CLS_DOT, CLS_OTHER: mode_proc = MODE_HALT;
        default:           ;
      endcase
    end
    flush     = eot && (mode_proc != MODE_HALT);
    mode_next = flush ? MODE_IDLE : mode_proc;
  end

  // token start after this byte, before any restart
  assign mark = fresh && (cls == CLS_LT || cls == CLS_GT ||
                          cls == CLS_DIGIT || cls == CLS_LETTER);
  assign ts_off_m  = mark ? off  : ts_off;
  assign ts_line_m = mark ? line : ts_line;
  assign ts_col_m  = mark ? col  : ts_col;

  // next positions; a halting byte leaves everything as it is
  always_comb begin
    off_next     = off;
    line_next    = line;
    col_next     = col;
    ts_off_next  = ts_off;
    ts_line_next = ts_line;
    ts_col_next  = ts_col;
    if (mode_proc != MODE_HALT) begin
      if (eot) begin
        off_next     = '0;
        line_next    = pos_t'(1);
        col_next     = pos_t'(1);
        ts_off_next  = '0;
        ts_line_next = pos_t'(1);
        ts_col_next  = pos_t'(1);
      end else begin
        off_next     = off_inc;
        ts_off_next  = ts_off_m;
        ts_line_next = ts_line_m;
        ts_col_next  = ts_col_m;
        if (fresh && cls == CLS_NEWLINE) begin
          line_next = sat_inc(line);
          col_next  = pos_t'(1);
        end else begin
          col_next  = sat_inc(col);
        end
      end
    end
  end

  // build up to two tokens: pending token, token of this byte, flush
  always_comb begin
    v1 = 1'b0;
    t1 = make_tok(KIND_IDENT, ts_off, off, ts_line, ts_col);
    unique case (mode)
      MODE_IDENT: v1 = fresh;
      MODE_INT, MODE_FRAC: begin
        v1 = fresh;
        t1 = make_tok(KIND_NUMBER, ts_off, off, ts_line, ts_col);
      end
      MODE_LT: begin
        v1 = 1'b1;
        t1 = (cls == CLS_EQ) ? make_tok(KIND_LE, ts_off, off_inc, ts_line, ts_col)
                             : make_tok(KIND_LT, ts_off, sat_inc(ts_off), ts_line, ts_col);
      end
      MODE_GT: begin
        v1 = 1'b1;
        t1 = (cls == CLS_EQ) ? make_tok(KIND_GE, ts_off, off_inc, ts_line, ts_col)
                             : make_tok(KIND_GT, ts_off, sat_inc(ts_off), ts_line, ts_col);
      end
      default: ;
    endcase

    v2 = fresh;
    t2 = make_tok(KIND_ERROR, off, off_inc, line, col);
    unique case (cls)
      CLS_LPAREN: t2.kind = KIND_LPAREN;
      CLS_RPAREN: t2.kind = KIND_RPAREN;
      CLS_PLUS:   t2.kind = KIND_PLUS;
      CLS_MINUS:  t2.kind = KIND_MINUS;
      CLS_STAR:   t2.kind = KIND_STAR;
      CLS_SLASH:  t2.kind = KIND_SLASH;
      CLS_EQ:     t2.kind = KIND_EQ;
      CLS_DOT, CLS_OTHER: t2.kind = KIND_ERROR;
      default:    v2 = 1'b0;
    endcase

    v3 = 1'b0;
    t3 = make_tok(KIND_IDENT, ts_off_m, off_inc, ts_line_m, ts_col_m);
    if (flush) begin
      unique case (mode_proc)
        MODE_IDENT: v3 = 1'b1;
        MODE_INT, MODE_FRAC: begin
          v3      = 1'b1;
          t3.kind = KIND_NUMBER;
        end
        MODE_LT, MODE_GT: begin
          v3 = 1'b1;
          t3 = make_tok((mode_proc == MODE_LT) ? KIND_LT : KIND_GT, ts_off_m,
                        sat_inc(ts_off_m), ts_line_m, ts_col_m);
        end
        default: ;
      endcase
    end

    // pack in order and mark the final one
    r0 = v1 ? t1 : (v2 ? t2 : t3);
    r1 = (v1 && v2) ? t2 : t3;
    n  = {1'b0, v1} + {1'b0, v2} + {1'b0, v3};
    if (n == 2'd1) r0.last_of_run = 1'b1;
    if (n == 2'd2) r1.last_of_run = 1'b1;
  end

  // take a word only when the buffer can hold two tokens after this cycle
  assign out_pop = (ocnt != 2'd0) && token_out.ready;
  assign room    = (ocnt == 2'd0) || (ocnt == 2'd1 && out_pop);
  assign pop     = head.valid && room;

  // scanner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      off     <= '0;
      line    <= pos_t'(1);
      col     <= pos_t'(1);
      ts_off  <= '0;
      ts_line <= pos_t'(1);
      ts_col  <= pos_t'(1);
    end else if (pop && live) begin
      mode    <= mode_next;
      off     <= off_next;
      line    <= line_next;
      col     <= col_next;
      ts_off  <= ts_off_next;
      ts_line <= ts_line_next;
      ts_col  <= ts_col_next;
    end
  end

  // output buffer count
  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else if (pop) begin
      ocnt <= live ? n : 2'd0;
    end else if (out_pop) begin
      ocnt <= ocnt - 2'd1;
    end
  end

  // output buffer payload
  always_ff @(posedge clk) begin
    if (pop) begin
      buf0 <= r0;
      buf1 <= r1;
    end else if (out_pop) begin
      buf0 <= buf1;
    end
  end

  assign token_out.valid         = (ocnt != 2'd0);
  assign token_out.token_kind    = buf0.kind;
  assign token_out.start_offset  = buf0.start_offset;
  assign token_out.end_offset    = buf0.end_offset;
  assign token_out.line_number   = buf0.line_number;
  assign token_out.column_number = buf0.column_number;
  assign token_out.last_of_run   = buf0.last_of_run;

endmodule

`default_nettype wire

/* rtl/core/exlx_checker.sv */
// Port-level checks of the expression lexer, bound to the top level.
// Depends on exlx_pkg for the token kinds and position type.
`default_nettype none

module exlx_checker
  import exlx_pkg::*;
  (
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_ready,
  input wire [3:0] token_kind,
  input wire pos_t start_offset,
  input wire pos_t end_offset,
  input wire pos_t line_number,
  input wire pos_t column_number,
  input wire       last_of_run
);

  // hold a stalled token
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("token dropped while stalled");

  // no token right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("token shown after reset");

  // an error token always closes its byte's run
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_ERROR |-> last_of_run)
    else $error("error token not last of run");

  // offsets are ordered; line and column are one-based
  a_positions: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> end_offset >= start_offset &&
                  line_number != '0 && column_number != '0)
    else $error("bad token positions");

endmodule

bind expression_lexer exlx_checker u_exlx_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (token_out.valid),
  .out_ready     (token_out.ready),
  .token_kind    (token_out.token_kind),
  .start_offset  (token_out.start_offset),
  .end_offset    (token_out.end_offset),
  .line_number   (token_out.line_number),
  .column_number (token_out.column_number),
  .last_of_run   (token_out.last_of_run)
);

`default_nettype wire
